>>> src/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types and constants for the SHA-256 byte stream hasher: channel
// payloads, controller command/status bundles, round constants, initial hash.
// ----------------------------------------------------------------------------
package s256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_pos;
    logic        last_word;
  } out_item_t;

  // Source of the byte shifted into the block buffer
  localparam logic [1:0] SEL_MSG  = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  typedef struct packed {
    logic       shift_byte;
    logic [1:0] byte_sel;
    logic       count_inc;
    logic       load_work;
    logic       round_en;
    logic [5:0] k_index;
    logic       add_chain;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } sts_t;

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> src/s256_stream_if.sv
// ----------------------------------------------------------------------------
// s256_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface s256_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/s256_datapath.sv
// ----------------------------------------------------------------------------
// s256_datapath
// Block buffer / schedule window, round unit, chaining words, bit count and
// digest drain register.
// ----------------------------------------------------------------------------
module s256_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  s256_pkg::cmd_t       cmd,
  output s256_pkg::sts_t       sts,
  s256_stream_if.source        out_ch
);

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  logic [31:0] win    [16];
  logic [31:0] work   [8];
  logic [31:0] chain  [8];
  logic [31:0] digest [8];
  logic [63:0] bit_count;
  logic [5:0]  fill;
  logic        out_valid;
  logic [2:0]  out_index;

  logic [7:0]  shift_in;
  logic [2:0]  len_idx;
  logic [31:0] w_next;
  logic [31:0] s0, s1, e1, a0, ch_v, maj_v, t1, t2;
  logic        out_take;

  assign len_idx = ~fill[2:0];

  always_comb begin
    case (cmd.byte_sel)
      s256_pkg::SEL_MSG:  shift_in = data_byte;
      s256_pkg::SEL_PAD:  shift_in = s256_pkg::PAD_BYTE;
      s256_pkg::SEL_LEN:  shift_in = bit_count[{len_idx, 3'b000} +: 8];
      default:            shift_in = 8'h00;
    endcase
  end

  // Window holds W[r..r+15]; next word is W[r+16]
  assign s0     = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
  assign s1     = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
  assign w_next = s1 + win[9] + s0 + win[0];

  assign e1    = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
  assign a0    = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
  assign ch_v  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj_v = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1    = work[7] + e1 + ch_v + s256_pkg::round_k(cmd.k_index) + win[0];
  assign t2    = a0 + maj_v;

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < 15; i++) win[i] <= {win[i][23:0], win[i+1][31:24]};
      win[15] <= {win[15][23:0], shift_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) work[i] <= chain[i];
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < 8; i++) chain[i] <= s256_pkg::INIT_H[i];
    end else if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
    end
  end

  assign out_take = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) digest[i] <= chain[i] + work[i];
    end else if (out_take) begin
      for (int i = 0; i < 7; i++) digest[i] <= digest[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= 64'd0;
      fill      <= 6'd0;
      out_valid <= 1'b0;
      out_index <= 3'd0;
    end else begin
      if (cmd.finish)         bit_count <= 64'd0;
      else if (cmd.count_inc) bit_count <= bit_count + 64'd8;
      if (cmd.shift_byte) fill <= fill + 6'd1;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        out_index <= 3'd0;
      end else if (out_take) begin
        out_index <= out_index + 3'd1;
        if (out_index == s256_pkg::LAST_WORD) out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = '{digest_word: digest[0], word_pos: out_index,
                            last_word: (out_index == s256_pkg::LAST_WORD)};

  assign sts.fill     = fill;
  assign sts.out_busy = out_valid;

endmodule

>>> src/s256_ctrl.sv
// ----------------------------------------------------------------------------
// s256_ctrl
// Sequencer: byte intake, padding, 64-round compression and digest hand-off.
// ----------------------------------------------------------------------------
module s256_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           has_byte,
  input  logic           end_of_message,
  output logic           in_ready,
  input  s256_pkg::sts_t sts,
  output s256_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_PAD   = 2'd3;

  logic [1:0] state, state_next;
  logic [5:0] rnd;
  logic       padding, pad_first, len_ok, final_blk;
  logic       accept, block_full, cur_len;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_ready && in_valid;
  assign block_full = (sts.fill == s256_pkg::LAST_POS);
  // length bytes go into this block if the 0x80 landed here early enough, or in the block before
  assign cur_len    = !pad_first && len_ok;

  always_comb begin
    cmd        = '0;
    cmd.k_index = rnd;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (has_byte) begin
            cmd.shift_byte = 1'b1;
            cmd.byte_sel   = s256_pkg::SEL_MSG;
            cmd.count_inc  = 1'b1;
          end
          if (has_byte && block_full) begin
            cmd.load_work = 1'b1;
            state_next    = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd == s256_pkg::LAST_RND) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (final_blk) begin
          // previous digest must be fully drained first
          if (!sts.out_busy) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.add_chain = 1'b1;
          state_next    = padding ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (pad_first)                           cmd.byte_sel = s256_pkg::SEL_PAD;
        else if (cur_len && sts.fill >= s256_pkg::LEN_POS) cmd.byte_sel = s256_pkg::SEL_LEN;
        else                                     cmd.byte_sel = s256_pkg::SEL_ZERO;
        if (block_full) begin
          cmd.load_work = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= 6'd0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.round_en) rnd <= rnd + 6'd1;
      if (accept && end_of_message) begin
        padding   <= 1'b1;
        pad_first <= 1'b1;
        len_ok    <= 1'b0;
        final_blk <= 1'b0;
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (block_full) begin
          final_blk <= cur_len;
          len_ok    <= 1'b1;
        end else if (pad_first) begin
          len_ok <= (sts.fill < s256_pkg::LEN_POS);
        end
      end
      if (cmd.finish) begin
        padding   <= 1'b0;
        final_blk <= 1'b0;
      end
    end
  end

endmodule

>>> src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: one byte (or end mark) per input transaction,
// eight digest words per message on the output channel.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                    | handshake
//  --------+-----+--------------------------------------------+------------
//  in_ch   | in  | data_byte[7:0], has_byte, end_of_message   | valid/ready
//  out_ch  | out | digest_word[31:0], word_pos[2:0], last_word | valid/ready
//
//  Bytes are taken one per cycle while the sequencer is idle. The 64th byte
//  of a block starts 64 rounds and then a chaining add, and no byte is taken
//  until that add is done. End of message pads one byte per cycle (up to 64
//  per block) and runs one or two compressions. The digest drains from its
//  own register, so intake of the next message overlaps a stalled output;
//  only the next final add waits.
//  Reset (rst, synchronous) loads the initial hash and clears counts.
//
module sha256_byte_stream_hasher (
  input  logic          clk,
  input  logic          rst,
  s256_stream_if.sink   in_ch,
  s256_stream_if.source out_ch
);

  s256_pkg::cmd_t cmd;     // controller -> datapath
  s256_pkg::sts_t sts;     // datapath -> controller
  logic           ready;

  s256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .has_byte       (in_ch.payload.has_byte),
    .end_of_message (in_ch.payload.end_of_message),
    .in_ready       (ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  assign in_ch.ready = ready;

  // Datapath: shift-register block buffer doubles as the schedule window
  s256_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (in_ch.payload.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

>>> src/s256_checker.sv
// ----------------------------------------------------------------------------
// s256_checker
// Port-level checks on the hasher's channels, bound to the top level.
// ----------------------------------------------------------------------------
module s256_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_eom,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_index,
  input logic       out_last
);

  // stalled digest word stays valid and keeps its index
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index))
    else $error("digest word changed while stalled");

  // words of one digest come back to back in order
  a_out_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_index == 3'($past(out_index) + 3'd1)))
    else $error("digest words out of sequence");

  // a new digest needs compression, never the next cycle
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("digest started right after last word");

  // end of message stops intake: padding follows, or first the rounds of a full block
  a_eom_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eom |=> !in_ready)
    else $error("input taken during padding");

  a_first_idx: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_index == 3'd0)
    else $error("digest did not start at word zero");

endmodule

bind sha256_byte_stream_hasher s256_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eom    (in_ch.payload.end_of_message),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.payload.word_pos),
  .out_last  (out_ch.payload.last_word)
);
